@@ rtl/ahbf_pkg.sv @@
// Shared types and constants for the audio half-buffer feeder.
// No dependencies; every other file refers to it by scoped names.
package ahbf_pkg;

    // Item kinds on the input channel
    typedef enum logic [2:0] {
        KIND_START = 3'd0,
        KIND_SLOT  = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_EOF   = 3'd3,
        KIND_ABORT = 3'd4
    } t_kind;

    // Run modes, also reported on the result channel
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STREAM = 2'd1,
        MODE_DRAIN  = 2'd2
    } t_mode;

    // Source fill result for a half
    typedef enum logic [1:0] {
        FILL_OK      = 2'd0,
        FILL_PARTIAL = 2'd1,
        FILL_EOF     = 2'd2,
        FILL_OTHER   = 2'd3
    } t_fill;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAMES_PER_HALF = 2'd0,
        CFG_SILENCE_HALVES  = 2'd1,
        CFG_MS_PER_HALF     = 2'd2
    } t_cfg_idx;

    localparam int FPH_W     = 13;
    localparam int SIL_W     = 8;
    localparam int MSH_W     = 16;
    localparam int SLOT_W    = 12;
    localparam int SAMPLE_W  = 16;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [FPH_W-1:0] MAX_HALF_FRAMES = 13'd4096;
    localparam logic [SIL_W-1:0] DEFAULT_SILENCE = 8'd4;
    localparam logic [1:0]       PREFILL_HALVES  = 2'd2;

    localparam logic [FPH_W-1:0] FPH_RESET = 13'd256;
    localparam logic [SIL_W-1:0] SIL_RESET = 8'd4;
    localparam logic [MSH_W-1:0] MSH_RESET = 16'd1;

endpackage

@@ rtl/ahbf_in_if.sv @@
// Input channel: one beat per frame slot or control event.
// Depends on ahbf_pkg for field widths.
interface ahbf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [2:0]                           kind;
    logic signed [ahbf_pkg::SAMPLE_W-1:0] sample;
    logic                                 sample_valid;
    logic [1:0]                           fill_status;

    modport source (output valid, kind, sample, sample_valid, fill_status, input ready);
    modport sink   (input valid, kind, sample, sample_valid, fill_status, output ready);
endinterface

@@ rtl/ahbf_out_if.sv @@
// Result channel: one beat per accepted input beat.
// Depends on ahbf_pkg for field widths.
interface ahbf_out_if;
    logic                             valid;
    logic                             ready;
    logic [ahbf_pkg::WORD_W-1:0]      wire_word;
    logic                             word_active;
    logic                             half_last;
    logic [1:0]                       mode;
    logic [ahbf_pkg::CNT_W-1:0]       chunks_done;
    logic [ahbf_pkg::CNT_W-1:0]       stream_ms;

    modport source (output valid, wire_word, word_active, half_last, mode, chunks_done,
                    stream_ms, input ready);
    modport sink   (input valid, wire_word, word_active, half_last, mode, chunks_done,
                    stream_ms, output ready);
endinterface

@@ rtl/audio_half_buffer_feeder_core.sv @@
// Audio half-buffer feeder: top level, the whole datapath and control.
// Depends on ahbf_pkg, ahbf_in_if and ahbf_out_if.
//
//  channel  | dir | handshake       | beat payload
//  ---------+-----+-----------------+-----------------------------------------------
//  i_in     | in  | valid/ready     | kind, sample, sample_valid, fill_status
//  o_out    | out | valid/ready     | wire_word, word_active, half_last, mode,
//           |     |                 | chunks_done, stream_ms
//  i_cfg_*  | in  | write enable    | i_cfg_idx selects register, i_cfg_data value
//
// One beat in, one beat out. A beat is taken in any cycle in which the result
// register is empty or is being drained, so the block sustains one beat per
// clock while o_out is ready; o_out.valid rises in the cycle after acceptance.
// All mode/half bookkeeping is a single combinational pass from the state
// registers into the next state and the result register.
// Reset (i_rst_n low, synchronous) returns to idle with counters cleared and
// configuration at 256 frames per half, 4 silent halves, 1 ms per half.
// A stalled o_out holds its beat and back-pressures i_in through ready.
module audio_half_buffer_feeder_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    ahbf_in_if.sink                              i_in,
    ahbf_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [ahbf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ahbf_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    // Configuration registers
    logic [ahbf_pkg::FPH_W-1:0] r_frames_per_half;
    logic [ahbf_pkg::SIL_W-1:0] r_silence_halves;
    logic [ahbf_pkg::MSH_W-1:0] r_ms_per_half;

    // Run state
    ahbf_pkg::t_mode             r_mode, n_mode;
    logic                        r_end_pending, n_end_pending;
    logic [ahbf_pkg::SIL_W-1:0]  r_silence_left, n_silence_left;
    logic [ahbf_pkg::SLOT_W-1:0] r_slot_index, n_slot_index;
    logic                        r_half_silent, n_half_silent;
    logic [1:0]                  r_prefill_left, n_prefill_left;
    logic [ahbf_pkg::CNT_W-1:0]  r_chunk_count, n_chunk_count;
    logic [ahbf_pkg::CNT_W-1:0]  r_time_ms, n_time_ms;

    // Result register
    logic                         r_out_valid;
    logic [ahbf_pkg::WORD_W-1:0]  r_out_word, n_out_word;
    logic                         r_out_active, n_out_active;
    logic                         r_out_last, n_out_last;

    logic                         in_take;
    logic [ahbf_pkg::FPH_W-1:0]   half_len;
    logic [ahbf_pkg::MSH_W-1:0]   ms_step;
    logic [ahbf_pkg::SIL_W-1:0]   sil_load;
    logic [ahbf_pkg::FPH_W-1:0]   slot_next;
    logic                         counted;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    // Clamp frames per half into 1..MAX_HALF_FRAMES
    always_comb begin
        if (r_frames_per_half == '0) begin
            half_len = ahbf_pkg::FPH_W'(1);
        end else if (r_frames_per_half > ahbf_pkg::MAX_HALF_FRAMES) begin
            half_len = ahbf_pkg::MAX_HALF_FRAMES;
        end else begin
            half_len = r_frames_per_half;
        end
    end

    assign ms_step   = (r_ms_per_half == '0) ? ahbf_pkg::MSH_W'(1) : r_ms_per_half;
    assign sil_load  = (r_silence_halves == '0) ? ahbf_pkg::DEFAULT_SILENCE
                                                : r_silence_halves;
    assign slot_next = {1'b0, r_slot_index} + ahbf_pkg::FPH_W'(1);

    // Next-state and result for the beat on i_in
    always_comb begin
        n_mode         = r_mode;
        n_end_pending  = r_end_pending;
        n_silence_left = r_silence_left;
        n_slot_index   = r_slot_index;
        n_half_silent  = r_half_silent;
        n_prefill_left = r_prefill_left;
        n_chunk_count  = r_chunk_count;
        n_time_ms      = r_time_ms;
        n_out_word     = '0;
        n_out_active   = 1'b0;
        n_out_last     = 1'b0;
        counted        = 1'b0;

        case (i_in.kind)
            ahbf_pkg::KIND_START: begin
                if (r_mode == ahbf_pkg::MODE_IDLE) begin
                    n_end_pending  = 1'b0;
                    n_silence_left = '0;
                    n_slot_index   = '0;
                    n_half_silent  = 1'b0;
                    n_chunk_count  = '0;
                    n_time_ms      = '0;
                    n_prefill_left = ahbf_pkg::PREFILL_HALVES;
                    n_mode         = ahbf_pkg::MODE_STREAM;
                end
            end
            ahbf_pkg::KIND_SLOT: begin
                if (r_mode != ahbf_pkg::MODE_IDLE) begin
                    // First slot of a half: pending end turns this half into drain
                    if (r_slot_index == '0) begin
                        if (r_mode == ahbf_pkg::MODE_STREAM && r_end_pending) begin
                            n_mode         = ahbf_pkg::MODE_DRAIN;
                            n_silence_left = sil_load;
                            n_end_pending  = 1'b0;
                        end
                        n_half_silent = (n_mode == ahbf_pkg::MODE_DRAIN);
                    end
                    n_out_active = 1'b1;
                    if (!n_half_silent && i_in.sample_valid) begin
                        n_out_word = {i_in.sample, i_in.sample};
                    end
                    if (slot_next >= half_len) begin
                        n_out_last   = 1'b1;
                        n_slot_index = '0;
                        counted      = (r_prefill_left == '0);
                        if (!counted) begin
                            n_prefill_left = r_prefill_left - 2'd1;
                        end else begin
                            n_time_ms = r_time_ms + ahbf_pkg::CNT_W'(ms_step);
                        end
                        if (n_mode == ahbf_pkg::MODE_DRAIN) begin
                            if (n_silence_left != '0) begin
                                n_silence_left = n_silence_left - ahbf_pkg::SIL_W'(1);
                            end
                            if (n_silence_left == '0) begin
                                n_mode         = ahbf_pkg::MODE_IDLE;
                                n_end_pending  = 1'b0;
                                n_slot_index   = '0;
                                n_half_silent  = 1'b0;
                            end
                        end else begin
                            if (counted && (i_in.fill_status == ahbf_pkg::FILL_OK ||
                                            i_in.fill_status == ahbf_pkg::FILL_PARTIAL)) begin
                                n_chunk_count = r_chunk_count + ahbf_pkg::CNT_W'(1);
                            end
                            if (i_in.fill_status == ahbf_pkg::FILL_EOF) begin
                                n_mode         = ahbf_pkg::MODE_DRAIN;
                                n_silence_left = sil_load;
                                n_end_pending  = 1'b0;
                            end
                        end
                    end else begin
                        n_slot_index = slot_next[ahbf_pkg::SLOT_W-1:0];
                    end
                end
            end
            ahbf_pkg::KIND_STOP: begin
                if (r_mode == ahbf_pkg::MODE_STREAM) begin
                    n_end_pending = 1'b1;
                end
            end
            ahbf_pkg::KIND_EOF: begin
                n_end_pending = 1'b1;
            end
            ahbf_pkg::KIND_ABORT: begin
                n_mode         = ahbf_pkg::MODE_IDLE;
                n_end_pending  = 1'b0;
                n_silence_left = '0;
                n_slot_index   = '0;
                n_half_silent  = 1'b0;
            end
            default: begin
                // unused kind codes: no state change
            end
        endcase
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_per_half <= ahbf_pkg::FPH_RESET;
            r_silence_halves  <= ahbf_pkg::SIL_RESET;
            r_ms_per_half     <= ahbf_pkg::MSH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ahbf_pkg::CFG_FRAMES_PER_HALF:
                    r_frames_per_half <= i_cfg_data[ahbf_pkg::FPH_W-1:0];
                ahbf_pkg::CFG_SILENCE_HALVES:
                    r_silence_halves  <= i_cfg_data[ahbf_pkg::SIL_W-1:0];
                ahbf_pkg::CFG_MS_PER_HALF:
                    r_ms_per_half     <= i_cfg_data[ahbf_pkg::MSH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // State and result-valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= ahbf_pkg::MODE_IDLE;
            r_end_pending  <= 1'b0;
            r_silence_left <= '0;
            r_slot_index   <= '0;
            r_half_silent  <= 1'b0;
            r_prefill_left <= '0;
            r_chunk_count  <= '0;
            r_time_ms      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_take) begin
                r_mode         <= n_mode;
                r_end_pending  <= n_end_pending;
                r_silence_left <= n_silence_left;
                r_slot_index   <= n_slot_index;
                r_half_silent  <= n_half_silent;
                r_prefill_left <= n_prefill_left;
                r_chunk_count  <= n_chunk_count;
                r_time_ms      <= n_time_ms;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_word   <= n_out_word;
            r_out_active <= n_out_active;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.wire_word   = r_out_word;
    assign o_out.word_active = r_out_active;
    assign o_out.half_last   = r_out_last;
    assign o_out.mode        = r_mode;
    assign o_out.chunks_done = r_chunk_count;
    assign o_out.stream_ms   = r_time_ms;

    // Checks
    a_last_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.half_last) |-> o_out.word_active)
        else $error("half_last without an active word");

    // an eof beat may leave end_pending set while idle
    a_idle_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ahbf_pkg::MODE_IDLE) |-> (r_slot_index == '0 && !r_half_silent))
        else $error("idle with half in progress");

    a_time_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_take |=> ($stable(r_time_ms) && $stable(r_chunk_count)))
        else $error("counters moved without an accepted beat");

    a_prefill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefill_left != 2'd3)
        else $error("prefill count out of range");

    a_drain_has_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ahbf_pkg::MODE_DRAIN) |-> (r_silence_left != '0))
        else $error("drain with no silent halves left");

endmodule
